>>> rtl/omms_pkg.sv
package omms_pkg;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned NUM_DBL  = 25;
  localparam int unsigned NUM_TRI  = 3;
  localparam int unsigned DBL_W    = $clog2(NUM_DBL + 1);
  localparam int unsigned TRI_W    = $clog2(NUM_TRI + 1);
  localparam int unsigned DBL_BASE = 128;
  localparam int unsigned TRI_BASE = 196;
  localparam int unsigned LINE_CMT_IDX  = 8;
  localparam int unsigned BLOCK_CMT_IDX = 9;
  localparam int unsigned MAX_RES  = 3;

  localparam logic [CHAR_W-1:0] CH_BANG  = 7'h21;
  localparam logic [CHAR_W-1:0] CH_PCT   = 7'h25;
  localparam logic [CHAR_W-1:0] CH_AMP   = 7'h26;
  localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_LT    = 7'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ    = 7'h3D;
  localparam logic [CHAR_W-1:0] CH_GT    = 7'h3E;
  localparam logic [CHAR_W-1:0] CH_CARET = 7'h5E;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 7'h7C;
  localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;

  // Two-character operators, in code order
  localparam logic [2*CHAR_W-1:0] DBL_TAB [NUM_DBL] = '{
    {CH_EQ, CH_EQ},       {CH_PLUS, CH_EQ},     {CH_PLUS, CH_PLUS},
    {CH_MINUS, CH_EQ},    {CH_MINUS, CH_MINUS}, {CH_MINUS, CH_GT},
    {CH_STAR, CH_EQ},     {CH_SLASH, CH_EQ},    {CH_SLASH, CH_SLASH},
    {CH_SLASH, CH_STAR},  {CH_PCT, CH_EQ},      {CH_AMP, CH_EQ},
    {CH_AMP, CH_AMP},     {CH_PIPE, CH_EQ},     {CH_PIPE, CH_PIPE},
    {CH_CARET, CH_EQ},    {CH_LT, CH_EQ},       {CH_LT, CH_LT},
    {CH_GT, CH_EQ},       {CH_GT, CH_GT},       {CH_BANG, CH_EQ},
    {CH_TILDE, CH_AMP},   {CH_TILDE, CH_PIPE},  {CH_TILDE, CH_CARET},
    {CH_COLON, CH_COLON}
  };

  localparam logic [3*CHAR_W-1:0] TRI_TAB [NUM_TRI] = '{
    {CH_LT, CH_LT, CH_EQ}, {CH_LT, CH_MINUS, CH_GT}, {CH_GT, CH_GT, CH_EQ}
  };

  typedef enum logic [1:0] {
    CMT_NONE  = 2'd0,
    CMT_LINE  = 2'd1,
    CMT_BLOCK = 2'd2
  } cmt_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] op_code;
    logic [1:0]        op_length;
    cmt_kind_e         comment_kind;
    logic              last;
  } res_t;

  // Index of a two-character operator, NUM_DBL when none
  function automatic logic [DBL_W-1:0] dbl_idx(input logic [CHAR_W-1:0] a,
                                               input logic [CHAR_W-1:0] b);
    logic [DBL_W-1:0] idx;
    idx = DBL_W'(NUM_DBL);
    for (int i = 0; i < NUM_DBL; i++) begin
      if (DBL_TAB[i] == {a, b}) idx = DBL_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [TRI_W-1:0] tri_idx(input logic [CHAR_W-1:0] a,
                                               input logic [CHAR_W-1:0] b,
                                               input logic [CHAR_W-1:0] c);
    logic [TRI_W-1:0] idx;
    idx = TRI_W'(NUM_TRI);
    for (int i = 0; i < NUM_TRI; i++) begin
      if (TRI_TAB[i] == {a, b, c}) idx = TRI_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/operator_max_munch_scanner.sv
// Path: an accepted item is held in the input register until the result buffer
//   can take it; its results are then registered in the buffer and offered on
//   the master side from there.
// Throughput: one item per cycle while each item gives at most one result and m_tready_i is high;
//   an item with k results (k is 0 to 3) holds off the next until its last result is being taken.
// Reset (rst_ni low, asynchronous): drop pending characters, the input register
//   and all buffered results; no payload register is cleared.
module operator_max_munch_scanner
  import omms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [6:0] sym_char, [7] zero
  input  logic        s_tlast_i,   // run_end
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [7:0] op_code, [9:8] op_length,
                                   // [11:10] comment_kind, [15:12] zero
  output logic        m_tlast_o    // last
);

  // Input register: one character and its run-end flag
  logic              in_vld_q, in_vld_d;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_end_q;

  // Scanner state: characters held back for a longer match
  logic [1:0]        pend_cnt_q, pend_cnt_d;
  logic [CHAR_W-1:0] pend_a_q, pend_a_d;
  logic [CHAR_W-1:0] pend_b_q, pend_b_d;

  // Result buffer: entry 0 is the head offered on the master side
  res_t              res_q [MAX_RES];
  res_t              res_d [MAX_RES];
  logic [1:0]        res_cnt_q, res_cnt_d;

  // Results of the item in the input register
  res_t              new_res [MAX_RES];
  logic [1:0]        new_cnt;

  logic              pop;
  logic              move;
  logic              s_fire;

  assign m_tvalid_o = (res_cnt_q != 2'd0);
  assign pop        = m_tvalid_o && m_tready_i;
  // Advance the input register into the buffer once the buffer drains
  assign move       = in_vld_q && ((res_cnt_q == 2'd0) ||
                                   ((res_cnt_q == 2'd1) && m_tready_i));
  assign s_tready_o = !in_vld_q || move;
  assign s_fire     = s_tvalid_i && s_tready_o;

  assign m_tdata_o = {4'b0, res_q[0].comment_kind, res_q[0].op_length, res_q[0].op_code};
  assign m_tlast_o = res_q[0].last;

  // Greedy longest-match scan over pending characters plus the new one
  always_comb begin
    logic [CHAR_W-1:0] a, b, c, x, y;
    logic              e, pair_go;
    logic [DBL_W-1:0]  d_ac, d_ab, d_bc, dxy;
    logic [TRI_W-1:0]  t;
    logic [1:0]        k;

    a       = pend_a_q;
    b       = pend_b_q;
    c       = in_char_q;
    e       = in_end_q;
    d_ac    = dbl_idx(a, c);
    d_ab    = dbl_idx(a, b);
    d_bc    = dbl_idx(b, c);
    t       = tri_idx(a, b, c);
    k       = 2'd0;
    pair_go = 1'b0;
    x       = a;
    y       = c;
    dxy     = d_ac;
    pend_cnt_d = 2'd0;
    pend_a_d   = '0;
    pend_b_d   = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i] = '{op_code: '0, op_length: 2'd1, comment_kind: CMT_NONE, last: 1'b0};
    end

    case (pend_cnt_q)
      2'd0: begin
        if (e) begin
          new_res[k].op_code = {1'b0, c};
          k = k + 2'd1;
        end else begin
          pend_cnt_d = 2'd1;
          pend_a_d   = c;
        end
      end
      2'd1: begin
        pair_go = 1'b1;
      end
      2'd2: begin
        if (t != TRI_W'(NUM_TRI)) begin
          new_res[k].op_code   = CODE_W'(TRI_BASE) + CODE_W'(t);
          new_res[k].op_length = 2'd3;
          k = k + 2'd1;
        end else if (d_ab != DBL_W'(NUM_DBL)) begin
          new_res[k].op_code   = CODE_W'(DBL_BASE) + CODE_W'(d_ab);
          new_res[k].op_length = 2'd2;
          k = k + 2'd1;
          if (e) begin
            new_res[k].op_code = {1'b0, c};
            k = k + 2'd1;
          end else begin
            pend_cnt_d = 2'd1;
            pend_a_d   = c;
          end
        end else begin
          // Fall back: emit the oldest character, rescan the remaining pair
          new_res[k].op_code = {1'b0, a};
          k = k + 2'd1;
          pair_go = 1'b1;
          x       = b;
          y       = c;
          dxy     = d_bc;
        end
      end
      default: begin
        pair_go = 1'b0;
      end
    endcase

    if (pair_go) begin
      if ((dxy == DBL_W'(LINE_CMT_IDX)) || (dxy == DBL_W'(BLOCK_CMT_IDX))) begin
        new_res[k].op_code      = CODE_W'(DBL_BASE) + CODE_W'(dxy);
        new_res[k].op_length    = 2'd2;
        new_res[k].comment_kind = (dxy == DBL_W'(LINE_CMT_IDX)) ? CMT_LINE : CMT_BLOCK;
        k = k + 2'd1;
      end else if (!e) begin
        pend_cnt_d = 2'd2;
        pend_a_d   = x;
        pend_b_d   = y;
      end else if (dxy != DBL_W'(NUM_DBL)) begin
        new_res[k].op_code   = CODE_W'(DBL_BASE) + CODE_W'(dxy);
        new_res[k].op_length = 2'd2;
        k = k + 2'd1;
      end else begin
        new_res[k].op_code = {1'b0, x};
        k = k + 2'd1;
        new_res[k].op_code = {1'b0, y};
        k = k + 2'd1;
      end
    end

    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i].last = (2'(i) == (k - 2'd1));
    end
    new_cnt = k;
  end

  // Load the buffer on a move, else shift the head out on a pop
  always_comb begin
    res_d     = res_q;
    res_cnt_d = res_cnt_q;
    if (move) begin
      res_d     = new_res;
      res_cnt_d = new_cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_tready_o) in_vld_d = s_tvalid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      res_cnt_q  <= 2'd0;
      pend_cnt_q <= 2'd0;
      pend_a_q   <= '0;
      pend_b_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_cnt_q <= res_cnt_d;
      if (move) begin
        pend_cnt_q <= pend_cnt_d;
        pend_a_q   <= pend_a_d;
        pend_b_q   <= pend_b_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_char_q <= s_tdata_i[CHAR_W-1:0];
      in_end_q  <= s_tlast_i;
    end
    res_q <= res_d;
  end

endmodule

>>> rtl/omms_checker.sv
module omms_checker
  import omms_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic [7:0]  s_tdata_i,
  input logic        s_tlast_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_o,
  input logic        m_tlast_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("stalled result changed");

  // Comment markers are only the two comment pairs
  a_cmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[11:10] != CMT_NONE) |->
      (m_tdata_o[9:8] == 2'd2) &&
      ((m_tdata_o[7:0] == CODE_W'(DBL_BASE + LINE_CMT_IDX) &&
        m_tdata_o[11:10] == CMT_LINE) ||
       (m_tdata_o[7:0] == CODE_W'(DBL_BASE + BLOCK_CMT_IDX) &&
        m_tdata_o[11:10] == CMT_BLOCK)))
    else $error("bad comment marker");

  // Triples sit in their code range
  a_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[9:8] == 2'd3) |->
      (m_tdata_o[7:0] >= CODE_W'(TRI_BASE)) &&
      (m_tdata_o[7:0] < CODE_W'(TRI_BASE + NUM_TRI)))
    else $error("bad triple code");

  // Singles carry their character and no comment kind
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[9:8] == 2'd1) |->
      !m_tdata_o[7] && (m_tdata_o[11:10] == CMT_NONE) && (m_tdata_o[15:12] == 4'd0))
    else $error("bad single result");

endmodule

bind operator_max_munch_scanner omms_checker u_omms_checker (.*);
